### hdl/top_n_insertion_sorter_core_defines.svh
// Assertion macros shared by the top-n insertion sorter RTL.
`ifndef TOP_N_INSERTION_SORTER_CORE_DEFINES_SVH
`define TOP_N_INSERTION_SORTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TNIS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("top_n_insertion_sorter_core: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TNIS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("top_n_insertion_sorter_core: next-cycle check failed");

`endif

### hdl/tnis_pkg.sv
// Types and constants of the top-n insertion sorter.
`timescale 1ns / 1ps

package tnis_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int OUT_SLOTS = 8;
  localparam int CNT_W     = 4;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]    count_t;

  localparam count_t COUNT_MAX = count_t'(15);

endpackage

### hdl/tnis_if.sv
// Valid/ready channel interfaces of the top-n insertion sorter.
`timescale 1ns / 1ps

interface tnis_in_if;
  logic              valid;
  logic              ready;
  logic              new_record;
  tnis_pkg::sample_t sample;

  modport source (output valid, output new_record, output sample, input ready);
  modport sink   (input valid, input new_record, input sample, output ready);
endinterface

interface tnis_out_if;
  logic              valid;
  logic              ready;
  tnis_pkg::sample_t slot_0;
  tnis_pkg::sample_t slot_1;
  tnis_pkg::sample_t slot_2;
  tnis_pkg::sample_t slot_3;
  tnis_pkg::sample_t slot_4;
  tnis_pkg::sample_t slot_5;
  tnis_pkg::sample_t slot_6;
  tnis_pkg::sample_t slot_7;
  logic              list_full;

  modport source (output valid, output slot_0, output slot_1, output slot_2,
                  output slot_3, output slot_4, output slot_5, output slot_6,
                  output slot_7, output list_full, input ready);
  modport sink   (input valid, input slot_0, input slot_1, input slot_2,
                  input slot_3, input slot_4, input slot_5, input slot_6,
                  input slot_7, input list_full, output ready);
endinterface

### hdl/top_n_insertion_sorter_core.sv
// Top-n insertion sorter: keeps the DEPTH largest samples of a record, sorted.
// Usage:
//   in_bus carries one beat per sample: new_record and a 16-bit sample.
//   out_bus carries one beat per input beat: the eight top slots, largest
//   first, after that sample was inserted, and list_full (the record holds
//   at least DEPTH samples). Slots at and beyond DEPTH read as zero.
//   A sample equal to a stored value lands above it; the smallest drops out.
//   new_record puts the sample in the top slot and zeroes all the others.
// Timing:
//   A beat is taken into the input register; once the result stage can
//   advance, the compare-and-shift of all slots in parallel feeds the slot
//   and result registers together, and the result shows on out_bus.
//   Throughput is one beat per cycle while out_bus.ready stays high.
// Reset (rst_n low, synchronous): slots and the item count clear to zero and
//   both stages empty; samples before the first record start are inserted
//   into the zeroed list.
// Stall: while out_bus.ready is low the result holds; one more beat is taken
//   into the input register, and then in_bus.ready drops until the result
//   is taken.
`timescale 1ns / 1ps

module top_n_insertion_sorter_core #(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  tnis_in_if.sink           in_bus,
  tnis_out_if.source        out_bus
);

  `include "top_n_insertion_sorter_core_defines.svh"

  localparam int PAD_N = (DEPTH > tnis_pkg::OUT_SLOTS) ? DEPTH : tnis_pkg::OUT_SLOTS;

  // Input stage.
  logic              s1_valid_r;
  logic              s1_start_r;
  tnis_pkg::sample_t s1_sample_r;

  // Sorted list and item count.
  tnis_pkg::sample_t slots_r   [DEPTH];
  tnis_pkg::sample_t slots_nxt [DEPTH];
  tnis_pkg::count_t  cnt_r;
  tnis_pkg::count_t  cnt_nxt;
  logic [DEPTH-1:0]  below;

  // Result stage.
  logic              out_valid_r;
  tnis_pkg::sample_t out_slots_r   [tnis_pkg::OUT_SLOTS];
  tnis_pkg::sample_t out_slots_nxt [tnis_pkg::OUT_SLOTS];
  tnis_pkg::sample_t slots_pad [PAD_N];
  logic              out_full_r;

  logic in_fire;
  logic adv;
  logic mv;
  logic slots_sorted;

  assign adv          = !out_valid_r || out_bus.ready;
  assign mv           = s1_valid_r && adv;
  assign in_bus.ready = !s1_valid_r || adv;
  assign in_fire      = in_bus.valid && in_bus.ready;

  // Every slot compares against the new sample at once; each slot then
  // keeps its value, takes the sample or its upper neighbor, or is cleared by a record start.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      below[i] = !s1_start_r && (slots_r[i] <= s1_sample_r);
    end
    slots_nxt[0] = (s1_start_r || below[0]) ? s1_sample_r : slots_r[0];
    for (int i = 1; i < DEPTH; i++) begin
      if (below[i]) begin
        slots_nxt[i] = below[i-1] ? slots_r[i-1] : s1_sample_r;
      end else begin
        slots_nxt[i] = s1_start_r ? '0 : slots_r[i];
      end
    end
  end

  always_comb begin
    if (s1_start_r) begin
      cnt_nxt = tnis_pkg::count_t'(1);
    end else if (cnt_r < tnis_pkg::COUNT_MAX) begin
      cnt_nxt = cnt_r + tnis_pkg::count_t'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_comb begin
    for (int i = 0; i < PAD_N; i++) begin
      slots_pad[i] = '0;
    end
    for (int i = 0; i < DEPTH; i++) begin
      slots_pad[i] = slots_nxt[i];
    end
    for (int i = 0; i < tnis_pkg::OUT_SLOTS; i++) begin
      out_slots_nxt[i] = slots_pad[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_start_r  <= in_bus.new_record;
      s1_sample_r <= in_bus.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        slots_r[i] <= '0;
      end
      cnt_r <= '0;
    end else if (mv) begin
      slots_r <= slots_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mv) begin
      out_slots_r <= out_slots_nxt;
      out_full_r  <= (cnt_nxt >= tnis_pkg::count_t'(DEPTH));
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.slot_0    = out_slots_r[0];
  assign out_bus.slot_1    = out_slots_r[1];
  assign out_bus.slot_2    = out_slots_r[2];
  assign out_bus.slot_3    = out_slots_r[3];
  assign out_bus.slot_4    = out_slots_r[4];
  assign out_bus.slot_5    = out_slots_r[5];
  assign out_bus.slot_6    = out_slots_r[6];
  assign out_bus.slot_7    = out_slots_r[7];
  assign out_bus.list_full = out_full_r;

  always_comb begin
    slots_sorted = 1'b1;
    for (int i = 1; i < DEPTH; i++) begin
      if (slots_r[i] > slots_r[i-1]) begin
        slots_sorted = 1'b0;
      end
    end
  end

  // The stored list stays in descending order at all times.
  `TNIS_ASSERT_IMP(a_slots_sorted, 1'b1, slots_sorted)
  // An item leaving the input stage always shows up as a result next cycle.
  `TNIS_ASSERT_NXT(a_result_loaded, mv, out_valid_r)
  // Once an item has been processed the record count is never zero.
  `TNIS_ASSERT_NXT(a_count_nonzero, mv, cnt_r != '0)

endmodule

### tb/sv/top_list_checker.sv
// Checker for the top-n insertion sorter: predicts each result beat and compares it.
`timescale 1ns / 1ps

module top_list_checker #(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  tnis_in_if          in_mon,
  tnis_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned lists_pending,
  output int unsigned lists_checked
);

  typedef struct packed {
    logic                                            full;
    tnis_pkg::sample_t [tnis_pkg::OUT_SLOTS-1:0]     slot;
  } top_list_t;

  // Our own copy of the sorter state: kept values, largest first, and the
  // saturating count of samples in the current record.
  tnis_pkg::sample_t kept [DEPTH];
  tnis_pkg::count_t  record_len;
  top_list_t         expected_lists [$];

  // Updates the kept list with one input beat and queues the list it should
  // produce. The list is always sorted, so the sample goes in at the first
  // entry that is not above it and everything from there on moves down.
  task automatic insert_sample(input logic start, input tnis_pkg::sample_t value);
    int        pos;
    top_list_t lst;
    if (start) begin
      for (int i = 0; i < DEPTH; i++) kept[i] = '0;
      kept[0]    = value;
      record_len = tnis_pkg::count_t'(1);
    end else begin
      pos = DEPTH;
      for (int i = DEPTH - 1; i >= 0; i--) begin
        if (kept[i] <= value) pos = i;
      end
      for (int j = DEPTH - 1; j > pos; j--) kept[j] = kept[j-1];
      if (pos < DEPTH) kept[pos] = value;
      if (record_len != tnis_pkg::COUNT_MAX) begin
        record_len = record_len + tnis_pkg::count_t'(1);
      end
    end
    for (int i = 0; i < tnis_pkg::OUT_SLOTS; i++) begin
      if (i < DEPTH) lst.slot[i] = kept[i];
      else lst.slot[i] = '0;
    end
    lst.full = (int'(record_len) >= DEPTH);
    expected_lists.push_back(lst);
  endtask

  task automatic check_list(input top_list_t got);
    top_list_t want;
    if (expected_lists.size() == 0) begin
      $display("%0t: result beat with nothing expected, actual %h", $time, got);
      fail_count++;
      return;
    end
    want = expected_lists.pop_front();
    lists_checked++;
    for (int i = 0; i < tnis_pkg::OUT_SLOTS; i++) begin
      if (got.slot[i] !== want.slot[i]) begin
        $display("%0t: slot_%0d expected %h actual %h", $time, i, want.slot[i], got.slot[i]);
        fail_count++;
      end
    end
    if (got.full !== want.full) begin
      $display("%0t: list_full expected %b actual %b", $time, want.full, got.full);
      fail_count++;
    end
  endtask

  initial begin
    fail_count    = 0;
    lists_pending = 0;
    lists_checked = 0;
    record_len    = '0;
    for (int i = 0; i < DEPTH; i++) kept[i] = '0;
  end

  always @(posedge clk) begin
    top_list_t got;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) insert_sample(in_mon.new_record, in_mon.sample);
      if (out_mon.valid && out_mon.ready) begin
        got.slot[0] = out_mon.slot_0;
        got.slot[1] = out_mon.slot_1;
        got.slot[2] = out_mon.slot_2;
        got.slot[3] = out_mon.slot_3;
        got.slot[4] = out_mon.slot_4;
        got.slot[5] = out_mon.slot_5;
        got.slot[6] = out_mon.slot_6;
        got.slot[7] = out_mon.slot_7;
        got.full    = out_mon.list_full;
        check_list(got);
      end
      lists_pending = expected_lists.size();
    end
  end

endmodule

### tb/sv/tb_top_n_insertion_sorter_core.sv
// Testbench top for the top-n insertion sorter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top_n_insertion_sorter_core;

  localparam int SORT_DEPTH  = 8;
  localparam int N_ITEMS     = 1950;
  localparam int QUIET_FROM  = N_ITEMS - 200;
  localparam int HOLD_AT     = 600;
  localparam int HOLD_CYCLES = 64;
  localparam int N_DIRECTED  = 23;

  logic clk;
  logic rst_n;

  tnis_in_if  in_ch ();
  tnis_out_if out_ch ();

  int unsigned fail_count;
  int unsigned lists_pending;
  int unsigned lists_checked;

  int unsigned beats_sent;
  int unsigned records_started;
  bit          idle_on;
  bit          hold_req;
  int          stall_left;

  // Each entry is {new_record, sample}.
  logic [16:0] directed_beats [N_DIRECTED] = '{
    // Before any record start: zero, maximum and mid values into the zeroed list.
    {1'b0, 16'h0000}, {1'b0, 16'hFFFF}, {1'b0, 16'h8000},
    // Record start with a zero sample, then a zero above the cleared entries.
    {1'b1, 16'h0000}, {1'b0, 16'h0000},
    // Equal values, extremes and more than eight samples so entries drop out.
    {1'b0, 16'h1234}, {1'b0, 16'h1234}, {1'b0, 16'hFFFF}, {1'b0, 16'h0001},
    {1'b0, 16'h8000}, {1'b0, 16'h7FFF}, {1'b0, 16'h1234}, {1'b0, 16'hFFFF},
    {1'b0, 16'h0002},
    // Push the record past fifteen samples so the count saturates.
    {1'b0, 16'h5555}, {1'b0, 16'hAAAA}, {1'b0, 16'h0000}, {1'b0, 16'hFFFF},
    {1'b0, 16'h0F0F}, {1'b0, 16'hF0F0}, {1'b0, 16'h0001},
    // Back-to-back record starts drop the full flag again.
    {1'b1, 16'hFFFF}, {1'b1, 16'h0001}
  };

  top_n_insertion_sorter_core #(
    .DEPTH (SORT_DEPTH)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  top_list_checker #(
    .DEPTH (SORT_DEPTH)
  ) list_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .lists_pending (lists_pending),
    .lists_checked (lists_checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Offers one beat and returns once it has been accepted; valid stays high
  // so the next call can present its beat without a gap.
  task automatic send_beat(input logic start, input tnis_pkg::sample_t value);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.new_record = start;
    in_ch.sample     = value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
    if (start) records_started++;
    idle_on = (beats_sent < QUIET_FROM) && ((beats_sent / 150) % 3 != 2);
    if (beats_sent == HOLD_AT) hold_req = 1'b1;
  endtask

  function automatic tnis_pkg::sample_t pick_sample(input tnis_pkg::sample_t prev);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return tnis_pkg::sample_t'($urandom_range(0, 7));
      4:       return prev;
      default: return tnis_pkg::sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Receiver: random short stalls, one long hold-off, none near the end.
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req     = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 99) < 15) begin
        out_ch.ready = 1'b0;
        stall_left   = $urandom_range(1, 5) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  initial begin
    tnis_pkg::sample_t prev;
    int                rec_len;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.new_record = 1'b0;
    in_ch.sample     = '0;
    beats_sent       = 0;
    records_started  = 0;
    idle_on          = 1'b1;
    hold_req         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_beat(directed_beats[i][16], directed_beats[i][15:0]);
    end

    // Random records: mostly up to two slot lists long, some much longer so
    // the count saturates; single-beat records give back-to-back starts.
    prev = '0;
    while (beats_sent < N_ITEMS) begin
      if ($urandom_range(0, 9) == 0) rec_len = $urandom_range(17, 40);
      else rec_len = $urandom_range(1, 16);
      prev = pick_sample(prev);
      send_beat(1'b1, prev);
      for (int k = 1; k < rec_len && beats_sent < N_ITEMS; k++) begin
        prev = pick_sample(prev);
        send_beat(1'b0, prev);
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (lists_pending == 0);
    repeat (10) @(posedge clk);

    $display("Sent %0d input beats in %0d records (%0d directed); %0d result beats checked.",
             beats_sent, records_started, N_DIRECTED, lists_checked);
    $display("Covered equal and extreme samples, count saturation and a %0d-cycle output stall.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
